/* rtl/dwt53_pkg.sv */
// ----------------------------------------------------------------------------
// dwt53_pkg
// Shared types and constants of the 2D 5/3 lifting wavelet tile transform.
// ----------------------------------------------------------------------------
package dwt53_pkg;

    // Input command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] REG_DIRECTION  = 8'd0;
    localparam logic [7:0] REG_TILE_ROWS  = 8'd1;
    localparam logic [7:0] REG_TILE_COLS  = 8'd2;
    localparam logic [7:0] REG_SCALING_ON = 8'd3;

    // Q1.16 band gains
    localparam logic signed [17:0] GAIN_SQRT2     = 18'sd92682;
    localparam logic signed [17:0] GAIN_INV_SQRT2 = 18'sd46341;

    // Write data select for both memories
    localparam logic [1:0] WSEL_SAMPLE = 2'd0;
    localparam logic [1:0] WSEL_MOVE   = 2'd1;
    localparam logic [1:0] WSEL_LIFT   = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] coeff;
        logic               status;
        logic               last_coeff;
    } t_out_word;

    typedef struct packed {
        logic       tile_we;
        logic       line_we;
        logic [1:0] wsel;
        logic       src_line;
        logic       prod_en;
        logic       scale_en;
        logic       gain_hi;
        logic       cap_c;
        logic       cap_l;
        logic       lift_pred;
        logic       lift_sub;
        logic       out_load;
        logic       out_nr;
        logic       out_last;
    } t_dp_cmd;

endpackage

/* rtl/dwt53_ram.sv */
// ----------------------------------------------------------------------------
// dwt53_ram
// Single-port RAM with one write or read per cycle and registered read data.
// ----------------------------------------------------------------------------
module dwt53_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dwt53_datapath.sv */
// ----------------------------------------------------------------------------
// dwt53_datapath
// Tile store, line buffer, gain multiplier, lifting adder and output register.
// ----------------------------------------------------------------------------
module dwt53_datapath #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLS     = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  dwt53_pkg::t_dp_cmd                   i_cmd,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] i_tile_addr,
    input  logic [$clog2((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS)-1:0] i_line_addr,
    input  logic signed [31:0]                   i_sample,
    output dwt53_pkg::t_out_word                 o_word
);

    localparam int LINE_LEN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int SATB     = (SAMPLE_WIDTH > 32) ? 32 :
                              ((SAMPLE_WIDTH < 16) ? 16 : SAMPLE_WIDTH);
    localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (SATB - 1)) - 36'sd1;
    localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;

    function automatic logic signed [31:0] sat(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = v;
        if (v > SAT_HI) begin
            t = SAT_HI;
        end else if (v < SAT_LO) begin
            t = SAT_LO;
        end
        return t[31:0];
    endfunction

    logic signed [31:0] w_tile_q;
    logic signed [31:0] w_line_q;
    logic signed [31:0] w_wdata;
    logic signed [31:0] w_src;
    logic signed [17:0] w_gain;
    logic signed [49:0] r_prod;
    logic signed [31:0] r_raw;
    logic signed [31:0] r_c;
    logic signed [31:0] r_l;
    logic signed [50:0] w_round;
    logic signed [31:0] w_move;
    logic signed [32:0] w_sum;
    logic signed [32:0] w_shift;
    logic signed [33:0] w_lift_full;
    logic signed [31:0] w_lift;
    dwt53_pkg::t_out_word r_out;

    dwt53_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tile (
        .i_clk  (i_clk),
        .i_we   (i_cmd.tile_we),
        .i_addr (i_tile_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_tile_q)
    );

    dwt53_ram #(.WIDTH(32), .DEPTH(LINE_LEN)) u_line (
        .i_clk  (i_clk),
        .i_we   (i_cmd.line_we),
        .i_addr (i_line_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_line_q)
    );

    assign w_src  = i_cmd.src_line ? w_line_q : w_tile_q;
    assign w_gain = i_cmd.gain_hi ? dwt53_pkg::GAIN_SQRT2 : dwt53_pkg::GAIN_INV_SQRT2;

    // Round to nearest with ties upwards, then back to Q16.16.
    assign w_round = {r_prod[49], r_prod} + 51'sd32768;
    assign w_move  = i_cmd.scale_en ? sat({w_round[50], w_round[50:16]}) : r_raw;

    // Predict uses half the neighbour sum, update a quarter.
    assign w_sum       = {r_l[31], r_l} + {w_line_q[31], w_line_q};
    assign w_shift     = i_cmd.lift_pred ? (w_sum >>> 1) : (w_sum >>> 2);
    assign w_lift_full = i_cmd.lift_sub ? ({{2{r_c[31]}}, r_c} - {w_shift[32], w_shift})
                                        : ({{2{r_c[31]}}, r_c} + {w_shift[32], w_shift});
    assign w_lift      = sat({{2{w_lift_full[33]}}, w_lift_full});

    always_comb begin
        case (i_cmd.wsel)
            dwt53_pkg::WSEL_SAMPLE: w_wdata = sat({{4{i_sample[31]}}, i_sample});
            dwt53_pkg::WSEL_MOVE:   w_wdata = w_move;
            dwt53_pkg::WSEL_LIFT:   w_wdata = w_lift;
            default:                w_wdata = w_move;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_en) begin
            r_prod <= 50'(w_src * w_gain);
            r_raw  <= w_src;
        end
        if (i_cmd.cap_c) begin
            r_c <= w_line_q;
        end
        if (i_cmd.cap_l) begin
            r_l <= w_line_q;
        end
        if (i_cmd.out_load) begin
            r_out.coeff      <= i_cmd.out_nr ? 32'sd0 : w_tile_q;
            r_out.status     <= i_cmd.out_nr;
            r_out.last_coeff <= i_cmd.out_last;
        end
    end

    assign o_word = r_out;

endmodule

/* rtl/dwt53_ctrl.sv */
// ----------------------------------------------------------------------------
// dwt53_ctrl
// Sequencer: loading, read-out, and the per-line load, lift and store passes.
// ----------------------------------------------------------------------------
module dwt53_ctrl #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_cmd,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_cfg_valid,
    input  logic [7:0]                           i_cfg_index,
    input  logic [7:0]                           i_cfg_data,
    output dwt53_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] o_tile_addr,
    output logic [$clog2((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS)-1:0] o_line_addr
);

    localparam int LINE_LEN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CW = $clog2(LINE_LEN + 2);
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int LW = $clog2(LINE_LEN);
    localparam int EW = (CW > 7) ? CW : 7;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDW  = 4'd1;
    localparam logic [3:0] ST_MV0  = 4'd2;
    localparam logic [3:0] ST_MV1  = 4'd3;
    localparam logic [3:0] ST_MV2  = 4'd4;
    localparam logic [3:0] ST_LF0  = 4'd5;
    localparam logic [3:0] ST_LF1  = 4'd6;
    localparam logic [3:0] ST_LF2  = 4'd7;
    localparam logic [3:0] ST_LF3  = 4'd8;

    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_A     = 2'd1;
    localparam logic [1:0] PH_B     = 2'd2;
    localparam logic [1:0] PH_STORE = 2'd3;

    logic [3:0]    r_state, n_state;
    logic          r_dir, n_dir;
    logic [6:0]    r_rows_cfg, n_rows_cfg;
    logic [6:0]    r_cols_cfg, n_cols_cfg;
    logic          r_scal, n_scal;
    logic          r_ready, n_ready;
    logic [CW-1:0] r_ld_row, n_ld_row, r_ld_col, n_ld_col;
    logic [AW-1:0] r_ld_base, n_ld_base;
    logic [CW-1:0] r_rd_row, n_rd_row, r_rd_col, n_rd_col;
    logic [AW-1:0] r_rd_base, n_rd_base;
    logic          r_col_mode, n_col_mode;
    logic          r_second, n_second;
    logic [CW-1:0] r_line, n_line;
    logic [AW-1:0] r_base, n_base;
    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_k, n_k;
    logic [AW-1:0] r_taddr, n_taddr;
    logic          r_out_valid, n_out_valid;
    logic          r_last, n_last;

    logic [EW-1:0] w_rows_ext, w_cols_ext;
    logic [CW-1:0] w_rows, w_cols, w_n, w_nlines, w_nlow, w_map, w_left, w_right;
    logic [CW-1:0] w_mv_idx, w_kp2;
    logic [AW-1:0] w_step, w_inc;
    logic          w_in_fire, w_out_fire, w_rd_last;
    dwt53_pkg::t_dp_cmd w_cmd;
    logic [CW-1:0] w_line_idx;

    // Dimensions as used: clamped to two and the configured maximum.
    always_comb begin
        w_rows_ext = EW'(r_rows_cfg);
        w_cols_ext = EW'(r_cols_cfg);
        if (w_rows_ext < EW'(2)) begin
            w_rows_ext = EW'(2);
        end else if (w_rows_ext > EW'(MAX_ROWS)) begin
            w_rows_ext = EW'(MAX_ROWS);
        end
        if (w_cols_ext < EW'(2)) begin
            w_cols_ext = EW'(2);
        end else if (w_cols_ext > EW'(MAX_COLS)) begin
            w_cols_ext = EW'(MAX_COLS);
        end
    end

    assign w_rows   = CW'(w_rows_ext);
    assign w_cols   = CW'(w_cols_ext);
    assign w_n      = r_col_mode ? w_rows : w_cols;
    assign w_nlines = r_col_mode ? w_cols : w_rows;
    assign w_step   = r_col_mode ? AW'(MAX_COLS) : AW'(1);
    assign w_inc    = r_col_mode ? AW'(1) : AW'(MAX_COLS);
    assign w_nlow   = (w_n + CW'(1)) >> 1;
    assign w_map    = (r_k < w_nlow) ? (r_k << 1) : (((r_k - w_nlow) << 1) | CW'(1));
    assign w_left   = (r_k == '0) ? CW'(1) : (r_k - CW'(1));
    assign w_right  = (r_k == w_n - CW'(1)) ? (w_n - CW'(2)) : (r_k + CW'(1));
    assign w_kp2    = r_k + CW'(2);
    // The deinterleaving map sits on the line buffer side of the scaled move.
    assign w_mv_idx = ((r_phase == PH_LOAD) == r_dir) ? w_map : r_k;

    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_out_fire = r_out_valid && !i_out_stall;
    assign w_rd_last  = (r_rd_row == w_rows - CW'(1)) && (r_rd_col == w_cols - CW'(1));

    always_comb begin
        n_state     = r_state;
        n_dir       = r_dir;
        n_rows_cfg  = r_rows_cfg;
        n_cols_cfg  = r_cols_cfg;
        n_scal      = r_scal;
        n_ready     = r_ready;
        n_ld_row    = r_ld_row;
        n_ld_col    = r_ld_col;
        n_ld_base   = r_ld_base;
        n_rd_row    = r_rd_row;
        n_rd_col    = r_rd_col;
        n_rd_base   = r_rd_base;
        n_col_mode  = r_col_mode;
        n_second    = r_second;
        n_line      = r_line;
        n_base      = r_base;
        n_phase     = r_phase;
        n_k         = r_k;
        n_taddr     = r_taddr;
        n_last      = r_last;
        n_out_valid = r_out_valid && !w_out_fire;

        w_cmd           = '0;
        w_cmd.wsel      = dwt53_pkg::WSEL_MOVE;
        w_cmd.src_line  = (r_phase == PH_STORE);
        w_cmd.gain_hi   = (r_k < w_nlow) ^ r_dir;
        w_cmd.scale_en  = r_scal && ((r_phase == PH_LOAD) ? r_dir : !r_dir);
        w_cmd.lift_pred = (r_phase == PH_A) ^ r_dir;
        w_cmd.lift_sub  = (r_phase == PH_A);
        o_tile_addr     = r_taddr;
        w_line_idx      = w_mv_idx;

        case (r_state)
            ST_IDLE: begin
                o_tile_addr = (i_in_cmd == dwt53_pkg::CMD_READ) ? (r_rd_base + AW'(r_rd_col))
                                                                : (r_ld_base + AW'(r_ld_col));
                if (w_in_fire && (i_in_cmd == dwt53_pkg::CMD_PUSH)) begin
                    if (!r_ready) begin
                        w_cmd.tile_we = 1'b1;
                        w_cmd.wsel    = dwt53_pkg::WSEL_SAMPLE;
                        if (r_ld_col == w_cols - CW'(1)) begin
                            n_ld_col  = '0;
                            n_ld_row  = r_ld_row + CW'(1);
                            n_ld_base = r_ld_base + AW'(MAX_COLS);
                            if (r_ld_row == w_rows - CW'(1)) begin
                                // Tile complete: start with rows (forward) or columns.
                                n_ld_row   = '0;
                                n_ld_base  = '0;
                                n_col_mode = r_dir;
                                n_second   = 1'b0;
                                n_line     = '0;
                                n_base     = '0;
                                n_taddr    = '0;
                                n_k        = '0;
                                n_phase    = PH_LOAD;
                                n_state    = ST_MV0;
                            end
                        end else begin
                            n_ld_col = r_ld_col + CW'(1);
                        end
                    end
                end else if (w_in_fire) begin
                    if (r_ready) begin
                        n_state = ST_RDW;
                        n_last  = w_rd_last;
                        if (r_rd_col == w_cols - CW'(1)) begin
                            n_rd_col  = '0;
                            n_rd_row  = r_rd_row + CW'(1);
                            n_rd_base = r_rd_base + AW'(MAX_COLS);
                        end else begin
                            n_rd_col = r_rd_col + CW'(1);
                        end
                        if (w_rd_last) begin
                            n_rd_row  = '0;
                            n_rd_col  = '0;
                            n_rd_base = '0;
                            n_ld_row  = '0;
                            n_ld_col  = '0;
                            n_ld_base = '0;
                            n_ready   = 1'b0;
                        end
                    end else begin
                        w_cmd.out_load = 1'b1;
                        w_cmd.out_nr   = 1'b1;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            ST_RDW: begin
                w_cmd.out_load = 1'b1;
                w_cmd.out_last = r_last;
                n_out_valid    = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_MV0: begin
                n_state = ST_MV1;
            end
            ST_MV1: begin
                w_cmd.prod_en = 1'b1;
                n_state       = ST_MV2;
            end
            ST_MV2: begin
                if (r_phase == PH_LOAD) begin
                    w_cmd.line_we = 1'b1;
                end else begin
                    w_cmd.tile_we = 1'b1;
                end
                if (r_k == w_n - CW'(1)) begin
                    if (r_phase == PH_LOAD) begin
                        n_phase = PH_A;
                        n_k     = r_dir ? CW'(0) : CW'(1);
                        n_state = ST_LF0;
                    end else if (r_line == w_nlines - CW'(1)) begin
                        if (!r_second) begin
                            n_second   = 1'b1;
                            n_col_mode = !r_col_mode;
                            n_line     = '0;
                            n_base     = '0;
                            n_taddr    = '0;
                            n_k        = '0;
                            n_phase    = PH_LOAD;
                            n_state    = ST_MV0;
                        end else begin
                            n_ready = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_line  = r_line + CW'(1);
                        n_base  = r_base + w_inc;
                        n_taddr = r_base + w_inc;
                        n_k     = '0;
                        n_phase = PH_LOAD;
                        n_state = ST_MV0;
                    end
                end else begin
                    n_k     = r_k + CW'(1);
                    n_taddr = r_taddr + w_step;
                    n_state = ST_MV0;
                end
            end
            ST_LF0: begin
                w_line_idx = r_k;
                n_state    = ST_LF1;
            end
            ST_LF1: begin
                w_line_idx  = w_left;
                w_cmd.cap_c = 1'b1;
                n_state     = ST_LF2;
            end
            ST_LF2: begin
                w_line_idx  = w_right;
                w_cmd.cap_l = 1'b1;
                n_state     = ST_LF3;
            end
            ST_LF3: begin
                w_line_idx    = r_k;
                w_cmd.line_we = 1'b1;
                w_cmd.wsel    = dwt53_pkg::WSEL_LIFT;
                if (w_kp2 >= w_n) begin
                    if (r_phase == PH_A) begin
                        n_phase = PH_B;
                        n_k     = r_dir ? CW'(1) : CW'(0);
                        n_state = ST_LF0;
                    end else begin
                        n_phase = PH_STORE;
                        n_k     = '0;
                        n_taddr = r_base;
                        n_state = ST_MV0;
                    end
                end else begin
                    n_k     = w_kp2;
                    n_state = ST_LF0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A write to one of the defined registers aborts the tile in progress.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                dwt53_pkg::REG_DIRECTION:  n_dir      = i_cfg_data[0];
                dwt53_pkg::REG_TILE_ROWS:  n_rows_cfg = i_cfg_data[6:0];
                dwt53_pkg::REG_TILE_COLS:  n_cols_cfg = i_cfg_data[6:0];
                dwt53_pkg::REG_SCALING_ON: n_scal     = i_cfg_data[0];
                default: begin
                end
            endcase
            if (i_cfg_index <= dwt53_pkg::REG_SCALING_ON) begin
                n_ld_row  = '0;
                n_ld_col  = '0;
                n_ld_base = '0;
                n_rd_row  = '0;
                n_rd_col  = '0;
                n_rd_base = '0;
                n_ready   = 1'b0;
                n_state   = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dir       <= 1'b0;
            r_rows_cfg  <= 7'd64;
            r_cols_cfg  <= 7'd64;
            r_scal      <= 1'b1;
            r_ready     <= 1'b0;
            r_ld_row    <= '0;
            r_ld_col    <= '0;
            r_ld_base   <= '0;
            r_rd_row    <= '0;
            r_rd_col    <= '0;
            r_rd_base   <= '0;
            r_col_mode  <= 1'b0;
            r_second    <= 1'b0;
            r_line      <= '0;
            r_base      <= '0;
            r_phase     <= PH_LOAD;
            r_k         <= '0;
            r_taddr     <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dir       <= n_dir;
            r_rows_cfg  <= n_rows_cfg;
            r_cols_cfg  <= n_cols_cfg;
            r_scal      <= n_scal;
            r_ready     <= n_ready;
            r_ld_row    <= n_ld_row;
            r_ld_col    <= n_ld_col;
            r_ld_base   <= n_ld_base;
            r_rd_row    <= n_rd_row;
            r_rd_col    <= n_rd_col;
            r_rd_base   <= n_rd_base;
            r_col_mode  <= n_col_mode;
            r_second    <= n_second;
            r_line      <= n_line;
            r_base      <= n_base;
            r_phase     <= n_phase;
            r_k         <= n_k;
            r_taddr     <= n_taddr;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;
    assign o_line_addr = w_line_idx[LW-1:0];

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !r_out_valid)
        else $error("output register loaded while a word is pending");

    a_lift_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LF3) |-> (r_k < w_n))
        else $error("lifting index beyond line length");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_RDW) |-> !r_ready)
        else $error("tile flagged ready during transform");

    a_tile_wr_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.tile_we && r_state != ST_IDLE) |-> (r_phase == PH_STORE))
        else $error("tile store written outside the store pass");
`endif

endmodule

/* rtl/dwt53_2d_tile_transform.sv */
// ----------------------------------------------------------------------------
// dwt53_2d_tile_transform
// One level of the 2D 5/3 lifting wavelet on a tile, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: words enter on i_word with i_valid/o_stall. A push word stores one
// sample in row-major order; pushes to a ready tile are dropped. When the
// last sample of the tile is in, the block transforms it (rows then columns
// forward, columns then rows inverse) and holds o_stall high meanwhile. Each
// line is fetched into the line buffer, lifted in two passes (three reads of
// the single-port line buffer per sample) and written back; the gains scale
// it on the way out when forward and on the way in when inverse, if enabled.
// A read word yields one output word on o_word via the tile store's read
// register and the output register, or from the output register alone with
// status set if no tile is ready. One result is held in the output register;
// while it is stalled by i_stall no further word is accepted. After the final
// coefficient the block waits for a new tile. Configuration writes on i_cfg_*
// are always taken; those to the four defined registers abort any tile.
// Reset clears counters and flags and restores the register defaults; the
// tile store is not cleared.
// ----------------------------------------------------------------------------
module dwt53_2d_tile_transform #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLS     = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  dwt53_pkg::t_in_word  i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output dwt53_pkg::t_out_word o_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int LINE_LEN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

    dwt53_pkg::t_dp_cmd                   w_cmd;
    logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] w_tile_addr;
    logic [$clog2(LINE_LEN)-1:0]          w_line_addr;

    dwt53_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_cmd   (i_word.cmd),
        .o_in_stall (o_stall),
        .o_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (w_cmd),
        .o_tile_addr(w_tile_addr),
        .o_line_addr(w_line_addr)
    );

    dwt53_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_tile_addr(w_tile_addr),
        .i_line_addr(w_line_addr),
        .i_sample   (i_word.sample),
        .o_word     (o_word)
    );

    assign o_cfg_ready = 1'b1;

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the 2D 5/3 lifting wavelet tile transform. A queue-fed driver
// offers push and read words, and a bit-accurate predictor works out the
// coefficient of every accepted read. A monitor checks each result word
// against the oldest prediction while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NCOLS   = 64;
    localparam int NROWS   = 64;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    dwt53_pkg::t_in_word  i_word;
    logic                 o_valid;
    logic                 i_stall;
    dwt53_pkg::t_out_word o_word;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [7:0]           i_cfg_index;
    logic [7:0]           i_cfg_data;

    dwt53_2d_tile_transform uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted state of the block.
    longint    tile_mem [NROWS*NCOLS];
    longint    lane [NROWS];
    int        pushed;
    int        fetched;
    bit        tile_full;
    bit        inverse;
    int        rows_reg;
    int        cols_reg;
    bit        gains_on;

    dwt53_pkg::t_in_word  pending_words [$];
    dwt53_pkg::t_out_word coeff_due [$];
    logic [15:0] cfg_writes [$];
    int        errors;
    int        words_queued;
    int        send_gap;
    int        recv_hold;
    int        results_seen;
    bit        quiet_phase;

    function automatic longint clip(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic longint gain(longint v, longint g);
        if (!gains_on) return v;
        return clip((v * g + 64'sd32768) >>> 16);
    endfunction

    function automatic int dim(int v);
        if (v < 2) return 2;
        if (v > 64) return 64;
        return v;
    endfunction

    function automatic void lift_line(int base, int step, int n, bit inv);
        int k;
        int nlo;
        int nhi;
        nlo = (n + 1) / 2;
        nhi = n / 2;
        if (!inv) begin
            for (k = 0; k < n; k++) lane[k] = tile_mem[base + k*step];
            for (k = 1; k + 1 < n; k += 2)
                lane[k] = clip(lane[k] - ((lane[k-1] + lane[k+1]) >>> 1));
            if (n % 2 == 0) lane[n-1] = clip(lane[n-1] - lane[n-2]);
            lane[0] = clip(lane[0] + (lane[1] >>> 1));
            for (k = 2; k + 1 < n; k += 2)
                lane[k] = clip(lane[k] + ((lane[k-1] + lane[k+1]) >>> 2));
            if (n % 2 == 1) lane[n-1] = clip(lane[n-1] + (lane[n-2] >>> 1));
            for (k = 0; k < nlo; k++)
                tile_mem[base + k*step] = gain(lane[2*k], 92682);
            for (k = 0; k < nhi; k++)
                tile_mem[base + (k+nlo)*step] = gain(lane[2*k+1], 46341);
        end else begin
            for (k = 0; k < nlo; k++) lane[2*k] = gain(tile_mem[base + k*step], 46341);
            for (k = 0; k < nhi; k++)
                lane[2*k+1] = gain(tile_mem[base + (k+nlo)*step], 92682);
            lane[0] = clip(lane[0] - (lane[1] >>> 1));
            for (k = 2; k + 1 < n; k += 2)
                lane[k] = clip(lane[k] - ((lane[k-1] + lane[k+1]) >>> 2));
            if (n % 2 == 1) lane[n-1] = clip(lane[n-1] - (lane[n-2] >>> 1));
            for (k = 1; k + 1 < n; k += 2)
                lane[k] = clip(lane[k] + ((lane[k-1] + lane[k+1]) >>> 1));
            if (n % 2 == 0) lane[n-1] = clip(lane[n-1] + lane[n-2]);
            for (k = 0; k < n; k++) tile_mem[base + k*step] = lane[k];
        end
    endfunction

    function automatic void transform_tile(int nr, int nc);
        int r;
        int c;
        if (!inverse) begin
            for (r = 0; r < nr; r++) lift_line(r*NCOLS, 1, nc, 1'b0);
            for (c = 0; c < nc; c++) lift_line(c, NCOLS, nr, 1'b0);
        end else begin
            for (c = 0; c < nc; c++) lift_line(c, NCOLS, nr, 1'b1);
            for (r = 0; r < nr; r++) lift_line(r*NCOLS, 1, nc, 1'b1);
        end
    endfunction

    function automatic void predict_word(dwt53_pkg::t_in_word w);
        int nr;
        int nc;
        int total;
        dwt53_pkg::t_out_word res;
        nr = dim(rows_reg);
        nc = dim(cols_reg);
        total = nr * nc;
        if (w.cmd == dwt53_pkg::CMD_PUSH) begin
            if (tile_full || pushed >= total) return;
            tile_mem[(pushed / nc)*NCOLS + pushed % nc] = longint'(w.sample);
            pushed++;
            if (pushed == total) begin
                transform_tile(nr, nc);
                tile_full = 1'b1;
                fetched = 0;
            end
            return;
        end
        res = '0;
        if (!tile_full || fetched >= total) begin
            res.status = 1'b1;
        end else begin
            res.coeff = tile_mem[(fetched / nc)*NCOLS + fetched % nc][31:0];
            res.last_coeff = (fetched + 1 == total);
            fetched++;
            if (fetched == total) begin
                fetched = 0;
                pushed = 0;
                tile_full = 1'b0;
            end
        end
        coeff_due.push_back(res);
    endfunction

    // Only the four defined registers abort the tile in progress.
    function automatic void apply_reg(logic [7:0] idx, logic [7:0] data);
        case (idx)
            dwt53_pkg::REG_DIRECTION:  inverse = data[0];
            dwt53_pkg::REG_TILE_ROWS:  rows_reg = int'(data[6:0]);
            dwt53_pkg::REG_TILE_COLS:  cols_reg = int'(data[6:0]);
            dwt53_pkg::REG_SCALING_ON: gains_on = data[0];
            default: ;
        endcase
        if (idx <= dwt53_pkg::REG_SCALING_ON) begin
            pushed = 0;
            fetched = 0;
            tile_full = 1'b0;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Word driver: the word on offer is held until the block takes it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_word(i_word);
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_word <= pending_words.pop_front();
                    i_valid <= 1'b1;
                    send_gap = quiet_phase ? 0 : $urandom_range(0, 10);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Configuration driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (!(i_cfg_valid && !o_cfg_ready)) begin
                if (cfg_writes.size() > 0) begin
                    {i_cfg_index, i_cfg_data} <= cfg_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own stall pattern.
    always @(posedge i_clk) begin
        dwt53_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (coeff_due.size() == 0) begin
                    $display("%0t: unexpected word expected none actual %h", $time, o_word);
                    errors++;
                end else begin
                    want = coeff_due.pop_front();
                    if (o_word.coeff !== want.coeff) begin
                        $display("%0t: coeff expected %h actual %h",
                                 $time, want.coeff, o_word.coeff);
                        errors++;
                    end
                    if (o_word.status !== want.status) begin
                        $display("%0t: status expected %b actual %b",
                                 $time, want.status, o_word.status);
                        errors++;
                    end
                    if (o_word.last_coeff !== want.last_coeff) begin
                        $display("%0t: last_coeff expected %b actual %b",
                                 $time, want.last_coeff, o_word.last_coeff);
                        errors++;
                    end
                end
                // One long hold-off lets the block fill up and stall its input.
                if (results_seen == 150) recv_hold = 400;
                else recv_hold = quiet_phase ? 0 : $urandom_range(0, 10);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
            2: return {$urandom_range(0, 1) ? 4'hF : 4'h0, 28'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(logic cmd, logic [31:0] value);
        dwt53_pkg::t_in_word w;
        w.cmd = cmd;
        w.sample = value;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Wait until everything sent has been answered; a finished tile that was
    // never read may still be under transform, so allow for that too.
    task automatic settle();
        do @(negedge i_clk);
        while (pending_words.size() > 0 || i_valid || coeff_due.size() > 0 || i_cfg_valid);
        if (tile_full) repeat (20 * dim(rows_reg) * dim(cols_reg) + 100) @(negedge i_clk);
        else repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] data);
        cfg_writes.push_back({idx, data});
        do @(negedge i_clk);
        while (cfg_writes.size() > 0 || i_cfg_valid);
    endtask

    // One tile with random content; noisy tiles mix in early reads and
    // pushes that land on a full tile. A cut tile stops part way through.
    task automatic queue_tile(bit noisy, bit cut);
        int total;
        int k;
        total = dim(rows_reg) * dim(cols_reg);
        for (k = 0; k < total; k++) begin
            if (cut && k == total / 2) return;
            if (noisy && $urandom_range(0, 15) == 0)
                queue_word(dwt53_pkg::CMD_READ, $urandom);
            queue_word(dwt53_pkg::CMD_PUSH, pick_sample());
        end
        if (noisy && $urandom_range(0, 1)) queue_word(dwt53_pkg::CMD_PUSH, $urandom);
        for (k = 0; k < total; k++) queue_word(dwt53_pkg::CMD_READ, $urandom);
        if (noisy && $urandom_range(0, 1)) queue_word(dwt53_pkg::CMD_READ, $urandom);
    endtask

    initial begin
        int t;
        int ntiles;
        logic [7:0] rsel;
        logic [7:0] csel;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        words_queued = 0;
        send_gap = 0;
        recv_hold = 0;
        results_seen = 0;
        quiet_phase = 1'b0;
        pushed = 0;
        fetched = 0;
        tile_full = 1'b0;
        inverse = 1'b0;
        rows_reg = 64;
        cols_reg = 64;
        gains_on = 1'b1;
        foreach (tile_mem[i]) tile_mem[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: saturating corners of a 2x2 tile, both ways.
        write_reg(dwt53_pkg::REG_TILE_ROWS, 8'd2);
        write_reg(dwt53_pkg::REG_TILE_COLS, 8'd2);
        queue_word(dwt53_pkg::CMD_READ, 32'h0);
        queue_word(dwt53_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        queue_word(dwt53_pkg::CMD_PUSH, 32'h8000_0000);
        queue_word(dwt53_pkg::CMD_PUSH, 32'h8000_0000);
        queue_word(dwt53_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        queue_word(dwt53_pkg::CMD_PUSH, 32'hFFFF_FFFF);
        repeat (5) queue_word(dwt53_pkg::CMD_READ, 32'hFFFF_FFFF);
        settle();
        write_reg(dwt53_pkg::REG_DIRECTION, 8'd1);
        write_reg(dwt53_pkg::REG_SCALING_ON, 8'd0);
        queue_word(dwt53_pkg::CMD_PUSH, 32'h0001_0000);
        queue_word(dwt53_pkg::CMD_PUSH, 32'hFFFF_0000);
        queue_word(dwt53_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        queue_word(dwt53_pkg::CMD_PUSH, 32'h8000_0000);
        repeat (4) queue_word(dwt53_pkg::CMD_READ, 32'h0);
        settle();

        // Random phases; some run without pauses, and a long receiver hold-off
        // backs up into the input.
        while (words_queued < 1650) begin
            settle();
            quiet_phase = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                rsel = $urandom_range(0, 1) ? 8'd127 : 8'd64;
                csel = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 1)) {rsel, csel} = {csel, rsel};
            end else begin
                rsel = 8'($urandom_range(2, 8)) | 8'($urandom_range(0, 1) << 7);
                csel = 8'($urandom_range(2, 8));
            end
            write_reg(dwt53_pkg::REG_DIRECTION, 8'($urandom));
            write_reg(dwt53_pkg::REG_TILE_ROWS, rsel);
            write_reg(dwt53_pkg::REG_TILE_COLS, csel);
            write_reg(dwt53_pkg::REG_SCALING_ON, 8'($urandom));
            if ($urandom_range(0, 5) == 0)
                write_reg(8'($urandom_range(4, 255)), 8'($urandom));
            ntiles = $urandom_range(1, 3);
            for (t = 0; t < ntiles; t++)
                queue_tile($urandom_range(0, 2) == 0, t == ntiles - 1 &&
                           $urandom_range(0, 5) == 0);
        end

        do @(negedge i_clk);
        while (pending_words.size() > 0 || i_valid || coeff_due.size() > 0);
        repeat (50) @(negedge i_clk);
        if (errors == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #(12 * 4_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
